// File: hdl/rrsm_pkg.sv
// rrsm_pkg: shared types and constants for the round-robin scheduler.
// Used by the top module and the checker; depends on nothing.
package rrsm_pkg;

  localparam int MAX_JOBS = 16;                       // power of two
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int TIME_W   = 24;
  localparam int JN_W     = 5;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_SLICE  = 3'd1,
    ST_FULL   = 3'd2,
    ST_ZERO   = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_CHK, S_LD_WR, S_RG_SWEEP, S_FS_CHK, S_HD_WAIT,
    S_EN_WAIT, S_EN_UPD, S_AR_CHK, S_FIN, S_OUT
  } fsm_t;

  typedef struct packed {
    logic [15:0]       arrival;
    logic [15:0]       burst;
    logic [15:0]       remaining;
    logic [JN_W-1:0]   id;
    logic [TIME_W-1:0] response;
  } job_t;

  typedef struct packed {
    status_t           status;
    logic [JN_W-1:0]   job_number;
    logic [TIME_W-1:0] slice_end_time;
    logic              job_finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] tat_span;
    logic [TIME_W-1:0] wait_span;
    logic [TIME_W-1:0] resp_span;
    logic              all_done;
  } res_t;

endpackage

// File: hdl/rrsm_ram.sv
// rrsm_ram: simple dual-port synchronous RAM, one write and one registered read.
// Generic; no package dependency.
module rrsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/round_robin_schedule_metrics_top.sv
// Round-robin scheduler top: control sequencer, job table RAM and ready ring RAM.
// Depends on rrsm_pkg and rrsm_ram.
//
// Usage: requests enter on the s_ channel (tuser = request type, tdata = arrival
// and burst), one result per request leaves on the m_ channel (tuser = status).
// time_quantum is written over the APB port; the user must write it only while
// the block is idle, which the block itself does not enforce. A load shifts the
// sorted job table one entry per cycle and then sweeps the 16-entry ready ring,
// the sweep skipped when the ring is empty.
// A run reads the ring head and the job entry, updates it, then scans the
// job table for new arrivals one entry per cycle; when the ring was empty,
// it first scans the table for a job not yet queued.
// Rejected, clear and empty requests go straight to the output state.
// One request is worked on at a time; the table RAM port sets the pace.
// The result sits in an output register; the next request is taken while it
// waits, and its own result holds in the sequencer until the register frees.
// Reset clears counters, time, ring pointers and the per-job flags; the RAM
// contents need no clearing since entries are written before they are read.
module round_robin_schedule_metrics_top
  import rrsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // arrival_time[15:0], burst_time[31:16]
  input  logic [1:0]   s_tuser,   // req_type[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // job_number[4:0], slice_end_time[28:5], job_finished[29],
  // finish_time[53:30], tat_span[77:54], wait_span[101:78],
  // resp_span[125:102], all_done[126], zero[127]
  output logic [127:0] m_tdata,
  output logic [2:0]   m_tuser,   // status[2:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  fsm_t state, state_next;

  logic [15:0]         time_quantum;
  logic [15:0]         arr_in, arr_in_next;
  logic [15:0]         bur_in, bur_in_next;
  logic [IDX_W-1:0]    ld_p, ld_p_next;
  logic [CNT_W-1:0]    sweep_k, sweep_k_next;
  logic [CNT_W-1:0]    scan_i, scan_i_next;
  logic [IDX_W-1:0]    idx, idx_next;
  job_t                entry, entry_next;
  logic [IDX_W-1:0]    ring_head, ring_head_next;
  logic [CNT_W-1:0]    ring_count, ring_count_next;
  logic [CNT_W-1:0]    jobs_loaded, jobs_loaded_next;
  logic [CNT_W-1:0]    jobs_completed, jobs_completed_next;
  logic [TIME_W-1:0]   now_time, now_time_next;
  logic [MAX_JOBS-1:0] started, started_next;
  logic [MAX_JOBS-1:0] queued, queued_next;
  res_t                res, res_next, out_res;

  logic                tab_we;
  logic [IDX_W-1:0]    tab_waddr, tab_raddr;
  job_t                tab_wdata, tab_rdata;
  logic                ring_we;
  logic [IDX_W-1:0]    ring_waddr, ring_raddr, ring_wdata, ring_rdata;

  logic                accept, out_free, scan_last, ld_shift, fs_hit, all_done_now;
  logic [IDX_W-1:0]    si;
  logic [15:0]         slice;
  logic [TIME_W:0]     t_sum;
  logic [TIME_W-1:0]   now_upd, tat, arr_ext;
  job_t                upd;

  rrsm_ram #(.WIDTH($bits(job_t)), .DEPTH(MAX_JOBS)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  rrsm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_JOBS)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign si        = scan_i[IDX_W-1:0];
  assign scan_last = ((scan_i + CNT_W'(1)) >= jobs_loaded);
  assign ld_shift  = (tab_rdata.arrival > arr_in);
  assign fs_hit    = !queued[si];
  assign all_done_now = (jobs_loaded != '0) && (jobs_completed >= jobs_loaded);

  // slice arithmetic on the fetched entry
  always_comb begin
    upd     = entry;
    arr_ext = {8'd0, entry.arrival};
    if (!started[idx]) begin
      upd.response = (now_time >= arr_ext) ? now_time - arr_ext : '0;
    end
    slice = entry.remaining;
    if (time_quantum != '0 && slice > time_quantum) begin
      slice = time_quantum;
    end
    t_sum   = {1'b0, now_time} + {9'd0, slice};
    now_upd = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
    upd.remaining = entry.remaining - slice;
    tat = now_time - arr_ext;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_OUT;
          if (s_tuser == REQ_LOAD) begin
            if (jobs_loaded < CNT_W'(MAX_JOBS) && s_tdata[31:16] != '0) begin
              state_next = (jobs_loaded == '0) ? S_LD_WR : S_LD_CHK;
            end
          end else if (s_tuser == REQ_RUN && jobs_completed < jobs_loaded) begin
            state_next = (ring_count == '0) ? S_FS_CHK : S_HD_WAIT;
          end
        end
      end
      S_LD_CHK:   state_next = (ld_shift && ld_p > IDX_W'(1)) ? S_LD_CHK : S_LD_WR;
      S_LD_WR:    state_next = (ring_count == '0) ? S_OUT : S_RG_SWEEP;
      S_RG_SWEEP: state_next = (sweep_k == CNT_W'(MAX_JOBS)) ? S_OUT : S_RG_SWEEP;
      S_FS_CHK: begin
        if (fs_hit)         state_next = S_EN_UPD;
        else if (scan_last) state_next = S_OUT;
      end
      S_HD_WAIT:  state_next = S_EN_WAIT;
      S_EN_WAIT:  state_next = S_EN_UPD;
      S_EN_UPD:   state_next = S_AR_CHK;
      S_AR_CHK:   state_next = scan_last ? S_FIN : S_AR_CHK;
      S_FIN:      state_next = S_OUT;
      S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    arr_in_next = arr_in;
    bur_in_next = bur_in;
    ld_p_next = ld_p;
    sweep_k_next = sweep_k;
    scan_i_next = scan_i;
    idx_next = idx;
    entry_next = entry;
    ring_head_next = ring_head;
    ring_count_next = ring_count;
    jobs_loaded_next = jobs_loaded;
    jobs_completed_next = jobs_completed;
    now_time_next = now_time;
    started_next = started;
    queued_next = queued;
    res_next = res;
    tab_we = 1'b0;
    tab_waddr = ld_p;
    tab_wdata = tab_rdata;
    tab_raddr = '0;
    ring_we = 1'b0;
    ring_waddr = ring_head + ring_count[IDX_W-1:0];
    ring_wdata = si;
    ring_raddr = ring_head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          arr_in_next = s_tdata[15:0];
          bur_in_next = s_tdata[31:16];
          res_next = '0;
          res_next.status = ST_NONE;
          res_next.all_done = all_done_now;
          ld_p_next = jobs_loaded[IDX_W-1:0];
          tab_raddr = jobs_loaded[IDX_W-1:0] - IDX_W'(1);
          scan_i_next = '0;
          if (s_tuser == REQ_LOAD) begin
            if (jobs_loaded >= CNT_W'(MAX_JOBS)) begin
              res_next.status = ST_FULL;
            end else if (s_tdata[31:16] == '0) begin
              res_next.status = ST_ZERO;
            end
          end else if (s_tuser == REQ_CLEAR) begin
            res_next.all_done = 1'b0;
            ring_head_next = '0;
            ring_count_next = '0;
            jobs_loaded_next = '0;
            jobs_completed_next = '0;
            now_time_next = '0;
            started_next = '0;
            queued_next = '0;
          end else if (s_tuser == REQ_RUN && ring_count == '0) begin
            tab_raddr = '0;
          end
        end
      end
      S_LD_CHK: begin
        if (ld_shift) begin
          tab_we = 1'b1;
          tab_waddr = ld_p;
          tab_wdata = tab_rdata;
          started_next[ld_p] = started[ld_p - IDX_W'(1)];
          queued_next[ld_p] = queued[ld_p - IDX_W'(1)];
          ld_p_next = ld_p - IDX_W'(1);
          tab_raddr = ld_p - IDX_W'(2);
        end
      end
      S_LD_WR: begin
        tab_we = 1'b1;
        tab_waddr = ld_p;
        tab_wdata.arrival = arr_in;
        tab_wdata.burst = bur_in;
        tab_wdata.remaining = bur_in;
        tab_wdata.id = JN_W'(jobs_loaded + CNT_W'(1));
        tab_wdata.response = '0;
        started_next[ld_p] = 1'b0;
        queued_next[ld_p] = 1'b0;
        jobs_loaded_next = jobs_loaded + CNT_W'(1);
        res_next = '0;
        res_next.status = ST_LOADED;
        res_next.job_number = JN_W'(jobs_loaded + CNT_W'(1));
        ring_raddr = '0;
        sweep_k_next = CNT_W'(1);
      end
      S_RG_SWEEP: begin
        // renumber ring slots at or above the insert point
        ring_raddr = sweep_k[IDX_W-1:0];
        sweep_k_next = sweep_k + CNT_W'(1);
        if (ring_rdata >= ld_p) begin
          ring_we = 1'b1;
          ring_waddr = sweep_k[IDX_W-1:0] - IDX_W'(1);
          ring_wdata = ring_rdata + IDX_W'(1);
        end
      end
      S_FS_CHK: begin
        // empty ring: the job found is pushed and popped at once
        if (fs_hit) begin
          if ({8'd0, tab_rdata.arrival} > now_time) begin
            now_time_next = {8'd0, tab_rdata.arrival};
          end
          queued_next[si] = 1'b1;
          ring_head_next = ring_head + IDX_W'(1);
          idx_next = si;
          entry_next = tab_rdata;
        end else begin
          scan_i_next = scan_i + CNT_W'(1);
          tab_raddr = si + IDX_W'(1);
        end
      end
      S_HD_WAIT: begin
        idx_next = ring_rdata;
        tab_raddr = ring_rdata;
        ring_head_next = ring_head + IDX_W'(1);
        ring_count_next = ring_count - CNT_W'(1);
      end
      S_EN_WAIT: begin
        entry_next = tab_rdata;
      end
      S_EN_UPD: begin
        entry_next = upd;
        started_next[idx] = 1'b1;
        now_time_next = now_upd;
        tab_we = 1'b1;
        tab_waddr = idx;
        tab_wdata = upd;
        scan_i_next = '0;
        tab_raddr = '0;
      end
      S_AR_CHK: begin
        if ({8'd0, tab_rdata.arrival} <= now_time && !queued[si]) begin
          queued_next[si] = 1'b1;
          if (ring_count < CNT_W'(MAX_JOBS)) begin
            ring_we = 1'b1;
            ring_count_next = ring_count + CNT_W'(1);
          end
        end
        scan_i_next = scan_i + CNT_W'(1);
        tab_raddr = si + IDX_W'(1);
      end
      S_FIN: begin
        res_next = '0;
        res_next.status = ST_SLICE;
        res_next.job_number = entry.id;
        res_next.slice_end_time = now_time;
        res_next.all_done = all_done_now;
        if (entry.remaining != '0) begin
          if (ring_count < CNT_W'(MAX_JOBS)) begin
            ring_we = 1'b1;
            ring_wdata = idx;
            ring_count_next = ring_count + CNT_W'(1);
          end
        end else begin
          jobs_completed_next = jobs_completed + CNT_W'(1);
          res_next.job_finished = 1'b1;
          res_next.finish_time = now_time;
          res_next.tat_span = tat;
          res_next.wait_span = (tat >= {8'd0, entry.burst}) ?
                               tat - {8'd0, entry.burst} : '0;
          res_next.resp_span = entry.response;
          res_next.all_done = (jobs_loaded != '0) &&
                              ((jobs_completed + CNT_W'(1)) >= jobs_loaded);
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ring_head <= '0;
      ring_count <= '0;
      jobs_loaded <= '0;
      jobs_completed <= '0;
      now_time <= '0;
      started <= '0;
      queued <= '0;
      time_quantum <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ring_head <= ring_head_next;
      ring_count <= ring_count_next;
      jobs_loaded <= jobs_loaded_next;
      jobs_completed <= jobs_completed_next;
      now_time <= now_time_next;
      started <= started_next;
      queued <= queued_next;
      if (psel && penable && pwrite && pready && !paddr[2]) begin
        time_quantum <= pwdata[15:0];
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    arr_in <= arr_in_next;
    bur_in <= bur_in_next;
    ld_p <= ld_p_next;
    sweep_k <= sweep_k_next;
    scan_i <= scan_i_next;
    idx <= idx_next;
    entry <= entry_next;
    res <= res_next;
    if (state == S_OUT && out_free) begin
      out_res <= res;
    end
  end

  assign pready = 1'b1;
  assign prdata = !paddr[2] ? {16'd0, time_quantum} : '0;

  assign m_tuser = out_res.status;
  assign m_tdata = {1'b0, out_res.all_done, out_res.resp_span, out_res.wait_span,
                    out_res.tat_span, out_res.finish_time,
                    out_res.job_finished, out_res.slice_end_time, out_res.job_number};

endmodule

// File: hdl/rrsm_checker.sv
// rrsm_checker: port-level assertions for the round-robin scheduler top.
// Depends on rrsm_pkg; bound to round_robin_schedule_metrics_top below.
module rrsm_checker
  import rrsm_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [2:0]   m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  a_reject_no_job: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_ZERO || m_tuser == ST_NONE)
    |-> m_tdata[4:0] == '0)
    else $error("rejected request carries a job number");

  a_finish_only_slice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_SLICE |-> !m_tdata[29])
    else $error("finish flag on a non-slice result");

endmodule

bind round_robin_schedule_metrics_top rrsm_checker u_rrsm_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
